>>> hw/rtl/wbls_pkg.sv
// ----------------------------------------------------------------------------
// wbls_pkg
// Shared constants for the strong Wolfe backtracking line-search controller:
// fixed-point formats, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package wbls_pkg;

  // Fraction bits of loss, slope and step values.
  localparam int FRAC_BITS  = 16;
  // Fraction bits of the constants c1, c2 and the shrink ratio.
  localparam int CONST_BITS = 16;
  localparam int VAL_W      = 32;
  localparam int TRIAL_W    = 7;
  localparam int MAX_TRIALS = 64;

  // Serial multiplier sequencing: one multiplier bit per cycle.
  localparam int MUL_A_CYCLES = CONST_BITS;
  localparam int MUL_B_CYCLES = VAL_W;
  localparam int CNT_W        = $clog2(MUL_B_CYCLES);

  // Result status codes.
  localparam logic [2:0] STATUS_NEXT     = 3'd0;
  localparam logic [2:0] STATUS_WOLFE    = 3'd1;
  localparam logic [2:0] STATUS_FALLBACK = 3'd2;
  localparam logic [2:0] STATUS_FAILED   = 3'd3;
  localparam logic [2:0] STATUS_ERROR    = 3'd4;

  // Input item kinds.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TRIAL = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECREASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGEST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;

  // Register reset values.
  localparam logic [CONST_BITS-1:0] RST_DECREASE  = 16'd7;
  localparam logic [CONST_BITS-1:0] RST_CURVATURE = 16'd58982;
  localparam logic [CONST_BITS-1:0] RST_SHRINK    = 16'd32768;
  localparam logic [VAL_W-1:0]      RST_LARGEST   = 32'd65536;
  localparam logic [TRIAL_W-1:0]    RST_LIMIT     = 7'd20;

endpackage

>>> hw/rtl/wolfe_backtracking_line_search_top.sv
// ----------------------------------------------------------------------------
// wolfe_backtracking_line_search_top
// A trial transaction runs through S_MUL_A (the c1, c2 and shrink products),
// S_MUL_B (the slope product) and S_FINISH (the decision); a start or a trial
// outside a search goes from S_IDLE straight to S_FINISH. No new item is
// accepted until the previous one has left S_FINISH, which waits while an
// unaccepted result is held. rst_n is synchronous, active low, and restores
// the register defaults with no search running.
// ----------------------------------------------------------------------------
module wolfe_backtracking_line_search_top
  import wbls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  // input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // base_loss[31:0], start_slope[63:32], trial_loss[95:64], trial_slope[127:96]
  input  logic [127:0]         in_tdata,
  // func[0]
  input  logic [0:0]           in_tuser,
  // result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // step_out[31:0], chosen_loss[63:32], chosen_slope[95:64], decrease_met[96],
  // curvature_met[97], trial_number[104:98], zero padding[111:105]
  output logic [111:0]         out_tdata,
  // status[2:0]
  output logic [2:0]           out_tuser
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MUL_A  = 2'd1;
  localparam logic [1:0] S_MUL_B  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [CNT_W-1:0]   CNT_A_LAST = CNT_W'(MUL_A_CYCLES - 1);
  localparam logic [CNT_W-1:0]   CNT_B_LAST = CNT_W'(MUL_B_CYCLES - 1);
  localparam logic [TRIAL_W-1:0] TRIAL_MAX  = TRIAL_W'(MAX_TRIALS);
  localparam logic [VAL_W-1:0]   SAT_MIN    = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0]   SAT_MAX    = {1'b0, {(VAL_W-1){1'b1}}};

  // configuration
  logic [CONST_BITS-1:0] c1_r, c2_r, shrink_r;
  logic [VAL_W-1:0]      largest_r;
  logic [TRIAL_W-1:0]    limit_r;

  // sequencing
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // captured item
  logic             func_r, func_nxt;
  logic [VAL_W-1:0] a_r, a_nxt;          // base loss or trial loss
  logic [VAL_W-1:0] b_r, b_nxt;          // start slope or trial slope
  logic [VAL_W-1:0] abs_ts_r, abs_ts_nxt;

  // search state
  logic               busy_r, busy_nxt;
  logic [VAL_W-1:0]   cur_step_r, cur_step_nxt;
  logic [TRIAL_W-1:0] trials_r, trials_nxt;
  logic [VAL_W-1:0]   hb_r, hb_nxt;      // held base loss
  logic [VAL_W-1:0]   hs_r, hs_nxt;      // held start slope
  logic [VAL_W-1:0]   habs_r, habs_nxt;  // magnitude of the held start slope
  logic               fb_valid_r, fb_valid_nxt;
  logic [VAL_W-1:0]   fb_step_r, fb_step_nxt;
  logic [VAL_W-1:0]   fb_loss_r, fb_loss_nxt;
  logic [VAL_W-1:0]   fb_slope_r, fb_slope_nxt;

  // serial multipliers
  logic [CONST_BITS-1:0] c1_sr_r, c1_sr_nxt, c2_sr_r, c2_sr_nxt, sh_sr_r, sh_sr_nxt;
  logic [VAL_W-1:0]      pm_hi_r, pm_hi_nxt;   // c1 * step, later shifted as multiplier
  logic [VAL_W-1:0]      cm_hi_r, cm_hi_nxt;   // c2 * |slope0|
  logic [VAL_W-1:0]      nm_hi_r, nm_hi_nxt;   // step * shrink ratio
  logic [VAL_W-1:0]      qh_r, qh_nxt;         // p * slope0, upper word
  logic [VAL_W-FRAC_BITS-1:0] ql_r, ql_nxt;    // bits shifted out below it

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_step_r, out_step_nxt;
  logic [VAL_W-1:0]   out_loss_r, out_loss_nxt;
  logic [VAL_W-1:0]   out_slope_r, out_slope_nxt;
  logic               out_dm_r, out_dm_nxt;
  logic               out_cm_r, out_cm_nxt;
  logic [TRIAL_W-1:0] out_tn_r, out_tn_nxt;

  // datapath
  logic [VAL_W:0]     pm_sum, cm_sum, nm_sum, q_sum;
  logic [VAL_W-1:0]   in_ts;
  logic               sat_ok;
  logic [VAL_W-1:0]   q_val;
  logic [VAL_W:0]     bound;
  logic               dm, cm, fb_take, cont, start_ok, fin_fire;
  logic [TRIAL_W-1:0] tn_inc;
  logic [VAL_W-1:0]   fb_step_eff, fb_loss_eff, fb_slope_eff;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_tn_r, out_cm_r, out_dm_r, out_slope_r, out_loss_r, out_step_r};

  // One shift-and-add step per cycle; the low bits of the unsigned products
  // fall away because only the part above the binary point is kept.
  assign pm_sum = {1'b0, pm_hi_r} + (c1_sr_r[0] ? {1'b0, cur_step_r} : '0);
  assign cm_sum = {1'b0, cm_hi_r} + (c2_sr_r[0] ? {1'b0, habs_r} : '0);
  assign nm_sum = {1'b0, nm_hi_r} + (sh_sr_r[0] ? {1'b0, cur_step_r} : '0);
  // Signed accumulation; taking bits [32:1] is a floor shift by one.
  assign q_sum  = {qh_r[VAL_W-1], qh_r} + (pm_hi_r[0] ? {hs_r[VAL_W-1], hs_r} : '0);

  assign in_ts = in_tdata[127:96];

  // The product shifted down by FRAC_BITS fits in 32 bits only when its top
  // bits are all copies of the sign.
  assign sat_ok = (&qh_r[VAL_W-1:FRAC_BITS-1]) || ~(|qh_r[VAL_W-1:FRAC_BITS-1]);
  assign q_val  = sat_ok ? {qh_r[FRAC_BITS-1:0], ql_r}
                         : (qh_r[VAL_W-1] ? SAT_MIN : SAT_MAX);
  assign bound  = {hb_r[VAL_W-1], hb_r} + {q_val[VAL_W-1], q_val};
  assign dm     = $signed({a_r[VAL_W-1], a_r}) <= $signed(bound);
  // |ts| * 2^16 <= c2 * |slope0| reduces to a compare against the upper word,
  // since the lower 16 bits of the left side are zero.
  assign cm     = abs_ts_r <= cm_hi_r;

  assign tn_inc  = trials_r + TRIAL_W'(1);
  assign fb_take = dm && !fb_valid_r;
  assign cont    = (tn_inc < limit_r) && (nm_hi_r != '0);
  assign fb_step_eff  = fb_take ? cur_step_r : fb_step_r;
  assign fb_loss_eff  = fb_take ? a_r : fb_loss_r;
  assign fb_slope_eff = fb_take ? b_r : fb_slope_r;

  assign start_ok = (c1_r != '0) && (c2_r != '0) && (c1_r < c2_r) && (shrink_r != '0) &&
                    (largest_r != '0) && (limit_r != '0) && (limit_r <= TRIAL_MAX) &&
                    b_r[VAL_W-1];

  assign fin_fire = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    abs_ts_nxt    = abs_ts_r;
    busy_nxt      = busy_r;
    cur_step_nxt  = cur_step_r;
    trials_nxt    = trials_r;
    hb_nxt        = hb_r;
    hs_nxt        = hs_r;
    habs_nxt      = habs_r;
    fb_valid_nxt  = fb_valid_r;
    fb_step_nxt   = fb_step_r;
    fb_loss_nxt   = fb_loss_r;
    fb_slope_nxt  = fb_slope_r;
    c1_sr_nxt     = c1_sr_r;
    c2_sr_nxt     = c2_sr_r;
    sh_sr_nxt     = sh_sr_r;
    pm_hi_nxt     = pm_hi_r;
    cm_hi_nxt     = cm_hi_r;
    nm_hi_nxt     = nm_hi_r;
    qh_nxt        = qh_r;
    ql_nxt        = ql_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_step_nxt  = out_step_r;
    out_loss_nxt  = out_loss_r;
    out_slope_nxt = out_slope_r;
    out_dm_nxt    = out_dm_r;
    out_cm_nxt    = out_cm_r;
    out_tn_nxt    = out_tn_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser[0];
          a_nxt      = (in_tuser[0] == FUNC_TRIAL) ? in_tdata[95:64] : in_tdata[31:0];
          b_nxt      = (in_tuser[0] == FUNC_TRIAL) ? in_ts : in_tdata[63:32];
          abs_ts_nxt = in_ts[VAL_W-1] ? (~in_ts + VAL_W'(1)) : in_ts;
          c1_sr_nxt  = c1_r;
          c2_sr_nxt  = c2_r;
          sh_sr_nxt  = shrink_r;
          pm_hi_nxt  = '0;
          cm_hi_nxt  = '0;
          nm_hi_nxt  = '0;
          cnt_nxt    = '0;
          state_nxt  = ((in_tuser[0] == FUNC_TRIAL) && busy_r) ? S_MUL_A : S_FINISH;
        end
      end
      S_MUL_A: begin
        pm_hi_nxt = pm_sum[VAL_W:1];
        cm_hi_nxt = cm_sum[VAL_W:1];
        nm_hi_nxt = nm_sum[VAL_W:1];
        c1_sr_nxt = c1_sr_r >> 1;
        c2_sr_nxt = c2_sr_r >> 1;
        sh_sr_nxt = sh_sr_r >> 1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_A_LAST) begin
          cnt_nxt   = '0;
          qh_nxt    = '0;
          ql_nxt    = '0;
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        // p now serves as the multiplier and is consumed from its low end.
        qh_nxt    = q_sum[VAL_W:1];
        ql_nxt    = {q_sum[0], ql_r[VAL_W-FRAC_BITS-1:1]};
        pm_hi_nxt = pm_hi_r >> 1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_B_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_fire) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_ERROR;
          out_step_nxt   = '0;
          out_loss_nxt   = '0;
          out_slope_nxt  = '0;
          out_dm_nxt     = 1'b0;
          out_cm_nxt     = 1'b0;
          out_tn_nxt     = '0;
          if (func_r == FUNC_START) begin
            busy_nxt = start_ok;
            if (start_ok) begin
              cur_step_nxt   = largest_r;
              trials_nxt     = '0;
              hb_nxt         = a_r;
              hs_nxt         = b_r;
              habs_nxt       = ~b_r + VAL_W'(1);
              fb_valid_nxt   = 1'b0;
              fb_step_nxt    = '0;
              fb_loss_nxt    = '0;
              fb_slope_nxt   = '0;
              out_status_nxt = STATUS_NEXT;
              out_step_nxt   = largest_r;
              out_loss_nxt   = a_r;
              out_slope_nxt  = b_r;
            end
          end else if (busy_r) begin
            trials_nxt = tn_inc;
            out_dm_nxt = dm;
            out_cm_nxt = cm;
            out_tn_nxt = tn_inc;
            if (dm && cm) begin
              busy_nxt       = 1'b0;
              out_status_nxt = STATUS_WOLFE;
              out_step_nxt   = cur_step_r;
              out_loss_nxt   = a_r;
              out_slope_nxt  = b_r;
            end else begin
              if (fb_take) begin
                fb_valid_nxt = 1'b1;
                fb_step_nxt  = cur_step_r;
                fb_loss_nxt  = a_r;
                fb_slope_nxt = b_r;
              end
              if (cont) begin
                cur_step_nxt   = nm_hi_r;
                out_status_nxt = STATUS_NEXT;
                out_step_nxt   = nm_hi_r;
              end else begin
                busy_nxt = 1'b0;
                if (fb_valid_r || fb_take) begin
                  out_status_nxt = STATUS_FALLBACK;
                  out_step_nxt   = fb_step_eff;
                  out_loss_nxt   = fb_loss_eff;
                  out_slope_nxt  = fb_slope_eff;
                end else begin
                  out_status_nxt = STATUS_FAILED;
                  out_loss_nxt   = hb_r;
                  out_slope_nxt  = hs_r;
                end
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r        <= RST_DECREASE;
      c2_r        <= RST_CURVATURE;
      shrink_r    <= RST_SHRINK;
      largest_r   <= RST_LARGEST;
      limit_r     <= RST_LIMIT;
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      trials_r    <= '0;
      fb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECREASE:  c1_r      <= cfg_wdata[CONST_BITS-1:0];
          CFG_CURVATURE: c2_r      <= cfg_wdata[CONST_BITS-1:0];
          CFG_SHRINK:    shrink_r  <= cfg_wdata[CONST_BITS-1:0];
          CFG_LARGEST:   largest_r <= cfg_wdata;
          CFG_LIMIT:     limit_r   <= cfg_wdata[TRIAL_W-1:0];
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      trials_r    <= trials_nxt;
      fb_valid_r  <= fb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    abs_ts_r     <= abs_ts_nxt;
    cur_step_r   <= cur_step_nxt;
    hb_r         <= hb_nxt;
    hs_r         <= hs_nxt;
    habs_r       <= habs_nxt;
    fb_step_r    <= fb_step_nxt;
    fb_loss_r    <= fb_loss_nxt;
    fb_slope_r   <= fb_slope_nxt;
    c1_sr_r      <= c1_sr_nxt;
    c2_sr_r      <= c2_sr_nxt;
    sh_sr_r      <= sh_sr_nxt;
    pm_hi_r      <= pm_hi_nxt;
    cm_hi_r      <= cm_hi_nxt;
    nm_hi_r      <= nm_hi_nxt;
    qh_r         <= qh_nxt;
    ql_r         <= ql_nxt;
    out_status_r <= out_status_nxt;
    out_step_r   <= out_step_nxt;
    out_loss_r   <= out_loss_nxt;
    out_slope_r  <= out_slope_nxt;
    out_dm_r     <= out_dm_nxt;
    out_cm_r     <= out_cm_nxt;
    out_tn_r     <= out_tn_nxt;
  end

endmodule
